>>> hw/rtl/crc_pair_board_match_table_core_macros.svh
// Assertion macros shared by the match table RTL.
`ifndef CRC_PAIR_BOARD_MATCH_TABLE_CORE_MACROS_SVH
`define CRC_PAIR_BOARD_MATCH_TABLE_CORE_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define CPBM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that a condition implies another in the following cycle.
`define CPBM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/cpbm_pkg.sv
package cpbm_pkg;

   // Table geometry and hit limit
   localparam int TABLE_DEPTH = 256;
   localparam int MAX_HITS    = 16;
   localparam int RESULT_CAP  = 16;
   localparam int HIT_LIMIT   = (MAX_HITS < RESULT_CAP) ? MAX_HITS : RESULT_CAP;

   // Field widths
   localparam int CMD_W    = 2;
   localparam int KEY_W    = 32;
   localparam int BOARD_W  = 16;
   localparam int STATUS_W = 2;
   localparam int SLOT_W   = 8;
   localparam int FILL_W   = $clog2(TABLE_DEPTH + 1);
   localparam int STEP_W   = $clog2(TABLE_DEPTH);
   localparam int HIT_W    = $clog2(HIT_LIMIT + 1);

   // Request commands
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
   localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

   // Response status codes
   localparam logic [STATUS_W-1:0] STATUS_DONE     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_MATCH    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NO_MATCH = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd3;

   typedef struct packed {
      logic [KEY_W-1:0]   primary_key;
      logic [KEY_W-1:0]   secondary_key;
      logic [BOARD_W-1:0] board_ident;
   } record_type;

   typedef struct packed {
      logic       valid;
      record_type rec;
   } entry_type;

   typedef struct packed {
      logic shift;
      logic clear;
   } chain_ctl_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [BOARD_W-1:0]  match_board;
      logic [SLOT_W-1:0]   match_slot;
      logic                truncated;
      logic                last;
   } result_type;

   // Reduce a table position to the reported slot width
   function automatic logic [SLOT_W-1:0] to_slot(input logic [STEP_W-1:0] idx);
      logic [31:0] wide;
      wide = 32'(idx);
      return wide[SLOT_W-1:0];
   endfunction

endpackage

>>> hw/rtl/cpbm_req_if.sv
interface cpbm_req_if;
   import cpbm_pkg::*;

   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   cmd;
   logic [KEY_W-1:0]   primary_key;
   logic [KEY_W-1:0]   secondary_key;
   logic [BOARD_W-1:0] board_ident;

   modport source (output valid, cmd, primary_key, secondary_key, board_ident,
                   input ready);
   modport sink (input valid, cmd, primary_key, secondary_key, board_ident,
                 output ready);
endinterface

>>> hw/rtl/cpbm_rsp_if.sv
interface cpbm_rsp_if;
   import cpbm_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [BOARD_W-1:0]  match_board;
   logic [SLOT_W-1:0]   match_slot;
   logic                truncated;
   logic                last;

   modport source (output valid, status, match_board, match_slot, truncated, last,
                   input ready);
   modport sink (input valid, status, match_board, match_slot, truncated, last,
                 output ready);
endinterface

>>> hw/rtl/cpbm_cell.sv
module cpbm_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  cpbm_pkg::chain_ctl_type ctl,
   input  cpbm_pkg::entry_type     link_in,
   output cpbm_pkg::entry_type     link_out
);
   import cpbm_pkg::*;

   logic       valid_ff, valid_in;
   record_type rec_ff, rec_in;

   // Take the neighbor's entry on a shift, drop occupancy on a clear
   always_comb begin
      valid_in = valid_ff;
      rec_in   = rec_ff;
      if (ctl.clear) begin
         valid_in = 1'b0;
      end else if (ctl.shift) begin
         valid_in = link_in.valid;
         rec_in   = link_in.rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      rec_ff <= rec_in;
   end

   assign link_out.valid = valid_ff;
   assign link_out.rec   = rec_ff;
endmodule

>>> hw/rtl/cpbm_scan_ctrl.sv
module cpbm_scan_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   cpbm_req_if.sink                req,
   cpbm_rsp_if.source              rsp,
   input  cpbm_pkg::entry_type     tail,
   output cpbm_pkg::entry_type     head,
   output cpbm_pkg::chain_ctl_type ctl
);
   import cpbm_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [STEP_W-1:0]  slot_ff, slot_in;
   logic [HIT_W-1:0]   hits_ff, hits_in;
   logic               more_ff, more_in;
   logic [KEY_W-1:0]   qpk_ff, qpk_in;
   logic [KEY_W-1:0]   qsk_ff, qsk_in;
   logic [BOARD_W-1:0] pend_board_ff, pend_board_in;
   logic [STEP_W-1:0]  pend_slot_ff, pend_slot_in;
   logic               out_valid_ff, out_valid_in;
   result_type         out_data_ff, out_data_in;

   logic       out_free;
   logic       accept;
   logic       hit;
   logic       emit;
   result_type emit_data;

   assign out_free  = !out_valid_ff || rsp.ready;
   assign req.ready = (state_ff == ST_IDLE) && out_free;
   assign accept    = req.valid && req.ready;

   // Compare the record leaving the tail against the held query
   assign hit = tail.valid && (tail.rec.primary_key == qpk_ff) &&
                ((tail.rec.secondary_key == '0) || (tail.rec.secondary_key == qsk_ff));

   // Sequence commands and the lookup rotation
   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      step_in       = step_ff;
      slot_in       = slot_ff;
      hits_in       = hits_ff;
      more_in       = more_ff;
      qpk_in        = qpk_ff;
      qsk_in        = qsk_ff;
      pend_board_in = pend_board_ff;
      pend_slot_in  = pend_slot_ff;
      ctl.shift     = 1'b0;
      ctl.clear     = 1'b0;
      head          = tail;
      emit          = 1'b0;
      emit_data     = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req.cmd)
                  CMD_CLEAR: begin
                     ctl.clear      = 1'b1;
                     fill_in        = '0;
                     emit           = 1'b1;
                     emit_data.status = STATUS_DONE;
                     emit_data.last = 1'b1;
                  end
                  CMD_INSERT: begin
                     emit           = 1'b1;
                     emit_data.last = 1'b1;
                     if (fill_ff == FILL_W'(TABLE_DEPTH)) begin
                        emit_data.status = STATUS_FULL;
                     end else begin
                        // Push the new record in at the head of the chain
                        ctl.shift              = 1'b1;
                        head.valid             = 1'b1;
                        head.rec.primary_key   = req.primary_key;
                        head.rec.secondary_key = req.secondary_key;
                        head.rec.board_ident   = req.board_ident;
                        fill_in                = fill_ff + 1'b1;
                        emit_data.status       = STATUS_DONE;
                     end
                  end
                  CMD_LOOKUP: begin
                     qpk_in   = req.primary_key;
                     qsk_in   = req.secondary_key;
                     step_in  = '0;
                     slot_in  = '0;
                     hits_in  = '0;
                     more_in  = 1'b0;
                     state_in = ST_SCAN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (out_free) begin
               // Rotate one record past the compare, tail back to head
               ctl.shift = 1'b1;
               if (tail.valid) begin
                  slot_in = slot_ff + 1'b1;
               end
               if (hit) begin
                  if (hits_ff < HIT_W'(HIT_LIMIT)) begin
                     // Release the previous hit, hold this one until the next
                     if (hits_ff != '0) begin
                        emit                  = 1'b1;
                        emit_data.status      = STATUS_MATCH;
                        emit_data.match_board = pend_board_ff;
                        emit_data.match_slot  = to_slot(pend_slot_ff);
                     end
                     pend_board_in = tail.rec.board_ident;
                     pend_slot_in  = slot_ff;
                     hits_in       = hits_ff + 1'b1;
                  end else begin
                     more_in = 1'b1;
                  end
               end
               step_in = step_ff + 1'b1;
               if (step_ff == STEP_W'(TABLE_DEPTH - 1)) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               emit           = 1'b1;
               emit_data.last = 1'b1;
               if (hits_ff != '0) begin
                  emit_data.status      = STATUS_MATCH;
                  emit_data.match_board = pend_board_ff;
                  emit_data.match_slot  = to_slot(pend_slot_ff);
                  emit_data.truncated   = more_ff;
               end else begin
                  emit_data.status = STATUS_NO_MATCH;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Load the response register, drop it once taken
   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_data_in  = emit_data;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         out_valid_ff <= out_valid_in;
      end
      step_ff       <= step_in;
      slot_ff       <= slot_in;
      hits_ff       <= hits_in;
      more_ff       <= more_in;
      qpk_ff        <= qpk_in;
      qsk_ff        <= qsk_in;
      pend_board_ff <= pend_board_in;
      pend_slot_ff  <= pend_slot_in;
      out_data_ff   <= out_data_in;
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.status      = out_data_ff.status;
   assign rsp.match_board = out_data_ff.match_board;
   assign rsp.match_slot  = out_data_ff.match_slot;
   assign rsp.truncated   = out_data_ff.truncated;
   assign rsp.last        = out_data_ff.last;
endmodule

>>> hw/rtl/crc_pair_board_match_table_core.sv
// Two-key match table with wildcard secondary key.
// Requests arrive on req_bus (cmd, primary_key, secondary_key, board_ident);
// responses leave on rsp_bus (status, match_board, match_slot, truncated,
// last), both valid/ready channels. Records live in a ring of TABLE_DEPTH
// cells; an insert pushes a record in at the head of the ring.
// Clear and insert: one request per cycle accepted while the receiver takes
// each response; the single response is in the output register the cycle
// after acceptance. Lookup: while the output is free, the ring rotates one
// record per cycle past a single comparator at its tail through every cell,
// then the final response is sent; the next request is accepted once that
// final response has been taken. Match responses leave in insertion order,
// each one sent when the following match (or the end of scan) is found.
// Reset clears the cell occupancy bits and the fill count at once; no
// clearing pass is needed and requests are taken right after reset.
// When the receiver stalls, the output register holds its response and
// the scan pauses in place; no request is taken while a response waits
// that cannot drain.
module crc_pair_board_match_table_core (
   input logic        clock,
   input logic        reset,
   cpbm_req_if.sink   req_bus,
   cpbm_rsp_if.source rsp_bus
);
   import cpbm_pkg::*;

   `include "crc_pair_board_match_table_core_macros.svh"

   entry_type     link [TABLE_DEPTH+1];
   chain_ctl_type ctl;

   logic req_take;
   logic short_take;
   logic clear_take;
   logic rsp_free;
   logic rsp_done;
   logic tail_valid;

   cpbm_scan_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus),
      .tail  (link[TABLE_DEPTH]),
      .head  (link[0]),
      .ctl   (ctl)
   );

   // Build the ring of record cells
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      cpbm_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .link_in  (link[i]),
         .link_out (link[i+1])
      );
   end

   // Collect the handshake terms watched by the checks
   assign req_take   = req_bus.valid && req_bus.ready;
   assign short_take = req_take && (req_bus.cmd == CMD_CLEAR || req_bus.cmd == CMD_INSERT);
   assign clear_take = req_take && (req_bus.cmd == CMD_CLEAR);
   assign rsp_free   = !rsp_bus.valid || rsp_bus.ready;
   assign rsp_done   = rsp_bus.valid && rsp_bus.last;
   assign tail_valid = link[TABLE_DEPTH].valid;

   `CPBM_ASSERT_SAME(a_clear_no_shift, clock, reset, ctl.clear, !ctl.shift, "clear with shift")
   `CPBM_ASSERT_SAME(a_accept_room, clock, reset, req_take, rsp_free, "request while blocked")
   `CPBM_ASSERT_NEXT(a_short_rsp, clock, reset, short_take, rsp_done, "no short response")
   `CPBM_ASSERT_NEXT(a_clear_empty, clock, reset, clear_take, !tail_valid, "tail kept on clear")
endmodule
